/* hw/rtl/ovle_pkg.sv */
package ovle_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int POS_W      = 5;

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [IDX_W-1:0]      addr_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [POS_W-1:0]      pos_type;

   typedef enum logic [1:0] {
      CMD_INSERT_FRONT = 2'd0,
      CMD_INSERT_BACK  = 2'd1,
      CMD_SEARCH       = 2'd2,
      CMD_DELETE       = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type            command;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type status;
      pos_type    position;
      pos_type    length;
   } rsp_type;

   typedef struct packed {
      logic     we;
      addr_type waddr;
      word_type wdata;
      addr_type raddr;
   } mem_req_type;

   // Map a list position onto a slot of the circular store.
   function automatic addr_type phys_addr(addr_type head, cnt_type idx);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(idx);
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic word_type to_word(logic signed [31:0] v);
      return DATA_WIDTH'(v);
   endfunction

   function automatic pos_type to_pos(cnt_type c);
      return POS_W'(c);
   endfunction

endpackage

/* hw/rtl/ordered_value_list_engine_core.sv */
// Ordered list of up to DEPTH signed words held in one circular RAM with a head pointer.
// Insert-front and insert-back write a single slot; the result is held in res_ff and then
// in the output register. Search and delete walk the list from the front, one RAM read
// per cycle; a delete then moves every later word down one slot, one read and one write
// per cycle. One command is worked on at a time; the result register lets the next
// command be taken while a result still waits on rsp_stall.
module ordered_value_list_engine_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ovle_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ovle_pkg::rsp_type rsp_item
);

   ovle_pkg::mem_req_type mem_req;
   ovle_pkg::word_type    rd_data;
   logic                  res_ready;
   logic                  res_valid;
   ovle_pkg::rsp_type     res_item;

   logic              rsp_valid_ff, rsp_valid_in;
   ovle_pkg::rsp_type rsp_item_ff, rsp_item_in;

   ovle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_stall (req_stall),
      .res_ready (res_ready),
      .res_valid (res_valid),
      .res_item  (res_item),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   ovle_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

/* hw/rtl/ovle_ram.sv */
module ovle_ram (
   input  logic                  clock,
   input  ovle_pkg::mem_req_type mem_req,
   output ovle_pkg::word_type    rd_data
);

   ovle_pkg::word_type mem [ovle_pkg::DEPTH];
   ovle_pkg::word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= mem[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ovle_ctrl.sv */
module ovle_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  ovle_pkg::req_type     req_item,
   output logic                  req_stall,
   input  logic                  res_ready,
   output logic                  res_valid,
   output ovle_pkg::rsp_type     res_item,
   output ovle_pkg::mem_req_type mem_req,
   input  ovle_pkg::word_type    rd_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_RESP
   } state_type;

   state_type          state_ff, state_in;
   ovle_pkg::addr_type head_ff, head_in;
   ovle_pkg::cnt_type  count_ff, count_in;
   ovle_pkg::word_type key_ff, key_in;
   logic               del_ff, del_in;
   ovle_pkg::cnt_type  cmp_idx_ff, cmp_idx_in;
   ovle_pkg::cnt_type  wr_idx_ff, wr_idx_in;
   ovle_pkg::rsp_type  res_ff, res_in;

   ovle_pkg::word_type word;
   ovle_pkg::addr_type head_dec;
   ovle_pkg::cnt_type  count_inc;
   ovle_pkg::cnt_type  count_dec;
   ovle_pkg::cnt_type  cmp_next;
   logic               full;
   logic               hit;

   assign word      = ovle_pkg::to_word(req_item.value);
   assign count_inc = count_ff + ovle_pkg::cnt_type'(1);
   assign count_dec = count_ff - ovle_pkg::cnt_type'(1);
   assign cmp_next  = cmp_idx_ff + ovle_pkg::cnt_type'(1);
   assign full      = (count_ff == ovle_pkg::cnt_type'(ovle_pkg::DEPTH));
   assign hit       = (rd_data == key_ff);
   assign head_dec  = (head_ff == '0) ? ovle_pkg::addr_type'(ovle_pkg::DEPTH - 1)
                                      : head_ff - ovle_pkg::addr_type'(1);

   assign req_stall = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_RESP);
   assign res_item  = res_ff;

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      key_in     = key_ff;
      del_in     = del_ff;
      cmp_idx_in = cmp_idx_ff;
      wr_idx_in  = wr_idx_ff;
      res_in     = res_ff;
      mem_req    = '0;
      mem_req.raddr = ovle_pkg::phys_addr(head_ff, cmp_next);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in          = word;
               del_in          = (req_item.command == ovle_pkg::CMD_DELETE);
               state_in        = S_RESP;
               res_in.status   = ovle_pkg::ST_OK;
               res_in.position = '0;
               res_in.length   = ovle_pkg::to_pos(count_ff);
               unique case (req_item.command) inside
                  ovle_pkg::CMD_INSERT_FRONT, ovle_pkg::CMD_INSERT_BACK: begin
                     if (full) begin
                        res_in.status = ovle_pkg::ST_FULL;
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.wdata = word;
                        count_in      = count_inc;
                        res_in.length = ovle_pkg::to_pos(count_inc);
                        if (req_item.command == ovle_pkg::CMD_INSERT_FRONT) begin
                           mem_req.waddr   = head_dec;
                           head_in         = head_dec;
                           res_in.position = ovle_pkg::pos_type'(1);
                        end else begin
                           mem_req.waddr   = ovle_pkg::phys_addr(head_ff, count_ff);
                           res_in.position = ovle_pkg::to_pos(count_inc);
                        end
                     end
                  end
                  ovle_pkg::CMD_SEARCH, ovle_pkg::CMD_DELETE: begin
                     if (count_ff == '0) begin
                        res_in.status = ovle_pkg::ST_EMPTY;
                     end else begin
                        // start the walk at the first word
                        mem_req.raddr = head_ff;
                        cmp_idx_in    = '0;
                        state_in      = S_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            // read data belongs to cmp_idx; the next word is already requested
            if (hit) begin
               res_in.status   = ovle_pkg::ST_OK;
               res_in.position = ovle_pkg::to_pos(cmp_next);
               res_in.length   = ovle_pkg::to_pos(count_ff);
               if (!del_ff) begin
                  state_in = S_RESP;
               end else if (cmp_next == count_ff) begin
                  count_in      = count_dec;
                  res_in.length = ovle_pkg::to_pos(count_dec);
                  state_in      = S_RESP;
               end else begin
                  wr_idx_in = cmp_idx_ff;
                  state_in  = S_SHIFT;
               end
            end else if (cmp_next == count_ff) begin
               res_in.status   = ovle_pkg::ST_NOT_FOUND;
               res_in.position = '0;
               res_in.length   = ovle_pkg::to_pos(count_ff);
               state_in        = S_RESP;
            end else begin
               cmp_idx_in = cmp_next;
            end
         end
         S_SHIFT: begin
            // move the word behind wr_idx down one place and fetch the next
            mem_req.we    = 1'b1;
            mem_req.waddr = ovle_pkg::phys_addr(head_ff, wr_idx_ff);
            mem_req.wdata = rd_data;
            mem_req.raddr = ovle_pkg::phys_addr(head_ff,
                                                wr_idx_ff + ovle_pkg::cnt_type'(2));
            wr_idx_in     = wr_idx_ff + ovle_pkg::cnt_type'(1);
            if (wr_idx_ff + ovle_pkg::cnt_type'(2) == count_ff) begin
               count_in      = count_dec;
               res_in.length = ovle_pkg::to_pos(count_dec);
               state_in      = S_RESP;
            end
         end
         S_RESP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      key_ff     <= key_in;
      del_ff     <= del_in;
      cmp_idx_ff <= cmp_idx_in;
      wr_idx_ff  <= wr_idx_in;
      res_ff     <= res_in;
   end

endmodule
